### sv/pwrbtn_pkg.sv
// Package for the power button hold sequencer.
// Holds the transaction structs, event, function and register index codes.
// No dependencies; used by every other file of the block.
package pwrbtn_pkg;

    localparam int unsigned TimerWidth = 16;
    localparam int unsigned MaxEvents  = 4;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [1:0] FUNC_DOWN = 2'd0;
    localparam logic [1:0] FUNC_UP   = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    localparam logic [2:0] EV_PRE_LOCK         = 3'd0;
    localparam logic [2:0] EV_ABORTED_LOCK     = 3'd1;
    localparam logic [2:0] EV_PRE_SHUTDOWN     = 3'd2;
    localparam logic [2:0] EV_ABORTED_SHUTDOWN = 3'd3;
    localparam logic [2:0] EV_LOCK_SCREEN      = 3'd4;
    localparam logic [2:0] EV_SHUTTING_DOWN    = 3'd5;
    localparam logic [2:0] EV_DIM_AND_SHUTDOWN = 3'd6;

    localparam logic [CfgIdxWidth-1:0] CFG_LOCK_HOLD        = 3'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_SHUTDOWN_HOLD    = 3'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_LOCK_TO_SHUTDOWN = 3'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_ANIMATION        = 3'd3;
    localparam logic [CfgIdxWidth-1:0] CFG_LEGACY_MODE      = 3'd4;

    localparam logic [TimerWidth-1:0] LOCK_HOLD_RESET        = 16'd400;
    localparam logic [TimerWidth-1:0] SHUTDOWN_HOLD_RESET    = 16'd400;
    localparam logic [TimerWidth-1:0] LOCK_TO_SHUTDOWN_RESET = 16'd600;
    localparam logic [TimerWidth-1:0] ANIMATION_RESET        = 16'd150;

    typedef struct packed {
        logic [1:0] func;
        logic       may_lock;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic       last;
    } result_t;

    function automatic logic [TimerWidth-1:0] period(input logic [TimerWidth-1:0] v);
        period = (v == '0) ? TimerWidth'(1) : v;
    endfunction

endpackage

### sv/power_button_hold_sequencer.sv
// Top level of the power button hold sequencer: timers, event batch and handshakes.
// Depends on pwrbtn_pkg for the transaction structs, codes and reset values.
//
//   channel   direction  handshake                payload
//   item      in         item_valid / item_stall  pwrbtn_pkg::item_t
//   res       out        res_valid / res_stall    pwrbtn_pkg::result_t
//   cfg       in         cfg_we                   cfg_index, cfg_data
//
// An accepted transaction is registered, then processed once the batch is free,
// which updates the timers and loads zero to four events into the batch register.
// The batch drains one event per cycle while res_stall is low, and the next
// transaction waits until the batch is free; the batch register sets the rate.
// A new transaction enters while the last event of the previous batch is taken.
// Reset clears the timers, the halting flag and all valid state.
module power_button_hold_sequencer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  pwrbtn_pkg::item_t                     item,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output pwrbtn_pkg::result_t                   res,
    input  logic                                  cfg_we,
    input  logic [pwrbtn_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [pwrbtn_pkg::TimerWidth-1:0]     cfg_data
);

    localparam int unsigned TW = pwrbtn_pkg::TimerWidth;

    logic [TW-1:0] lock_hold_reg, shutdown_hold_reg, l2s_hold_reg, anim_hold_reg;
    logic          legacy_reg;

    logic [TW-1:0] lock_cnt_reg, l2s_cnt_reg, shut_cnt_reg, anim_cnt_reg;
    logic [TW-1:0] lock_cnt_next, l2s_cnt_next, shut_cnt_next, anim_cnt_next;
    logic          halting_reg, halting_next;

    logic              in_vld_reg;
    pwrbtn_pkg::item_t in_reg;

    logic [2:0] batch_ev_reg [pwrbtn_pkg::MaxEvents];
    logic [2:0] batch_ev_next [pwrbtn_pkg::MaxEvents];
    logic [2:0] rem_reg, n_next;
    logic [1:0] idx_reg;

    logic take, batch_free, advance, item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_hold_reg     <= pwrbtn_pkg::LOCK_HOLD_RESET;
            shutdown_hold_reg <= pwrbtn_pkg::SHUTDOWN_HOLD_RESET;
            l2s_hold_reg      <= pwrbtn_pkg::LOCK_TO_SHUTDOWN_RESET;
            anim_hold_reg     <= pwrbtn_pkg::ANIMATION_RESET;
            legacy_reg        <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwrbtn_pkg::CFG_LOCK_HOLD:        lock_hold_reg     <= cfg_data;
                pwrbtn_pkg::CFG_SHUTDOWN_HOLD:    shutdown_hold_reg <= cfg_data;
                pwrbtn_pkg::CFG_LOCK_TO_SHUTDOWN: l2s_hold_reg      <= cfg_data;
                pwrbtn_pkg::CFG_ANIMATION:        anim_hold_reg     <= cfg_data;
                pwrbtn_pkg::CFG_LEGACY_MODE:      legacy_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign take       = res_valid && !res_stall;
    assign batch_free = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && take);
    assign advance    = in_vld_reg && batch_free;
    assign item_stall = in_vld_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        logic       e_lock, e_l2s, e_shut, e_anim;
        logic [2:0] n;
        lock_cnt_next = lock_cnt_reg;
        l2s_cnt_next  = l2s_cnt_reg;
        shut_cnt_next = shut_cnt_reg;
        anim_cnt_next = anim_cnt_reg;
        halting_next  = halting_reg;
        n = 3'd0;
        for (int i = 0; i < pwrbtn_pkg::MaxEvents; i++)
        begin
            batch_ev_next[i] = pwrbtn_pkg::EV_PRE_LOCK;
        end
        e_lock = 1'b0;
        e_l2s  = 1'b0;
        e_shut = 1'b0;
        e_anim = 1'b0;

        case (in_reg.func)
            pwrbtn_pkg::FUNC_DOWN:
            begin
                if (!halting_reg)
                begin
                    if (legacy_reg)
                    begin
                        if (in_reg.may_lock)
                        begin
                            batch_ev_next[0] = pwrbtn_pkg::EV_LOCK_SCREEN;
                        end
                        else
                        begin
                            shut_cnt_next    = '0;
                            halting_next     = 1'b1;
                            batch_ev_next[0] = pwrbtn_pkg::EV_SHUTTING_DOWN;
                            anim_cnt_next    = pwrbtn_pkg::period(anim_hold_reg);
                        end
                    end
                    else if (in_reg.may_lock)
                    begin
                        batch_ev_next[0] = pwrbtn_pkg::EV_PRE_LOCK;
                        lock_cnt_next    = pwrbtn_pkg::period(lock_hold_reg);
                    end
                    else
                    begin
                        batch_ev_next[0] = pwrbtn_pkg::EV_PRE_SHUTDOWN;
                        shut_cnt_next    = pwrbtn_pkg::period(shutdown_hold_reg);
                    end
                    n = 3'd1;
                end
            end
            pwrbtn_pkg::FUNC_UP:
            begin
                if (!halting_reg && !legacy_reg)
                begin
                    if (lock_cnt_reg != '0)
                    begin
                        lock_cnt_next = '0;
                        batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_ABORTED_LOCK;
                        n = n + 3'd1;
                    end
                    if (shut_cnt_reg != '0)
                    begin
                        shut_cnt_next = '0;
                        batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_ABORTED_SHUTDOWN;
                        n = n + 3'd1;
                    end
                    l2s_cnt_next = '0;
                end
            end
            pwrbtn_pkg::FUNC_TICK:
            begin
                if (lock_cnt_reg != '0) lock_cnt_next = lock_cnt_reg - TW'(1);
                if (l2s_cnt_reg != '0)  l2s_cnt_next  = l2s_cnt_reg - TW'(1);
                if (shut_cnt_reg != '0) shut_cnt_next = shut_cnt_reg - TW'(1);
                if (anim_cnt_reg != '0) anim_cnt_next = anim_cnt_reg - TW'(1);
                e_lock = (lock_cnt_reg == TW'(1));
                e_l2s  = (l2s_cnt_reg == TW'(1));
                e_shut = (shut_cnt_reg == TW'(1));
                e_anim = (anim_cnt_reg == TW'(1));
                if (e_lock)
                begin
                    batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_LOCK_SCREEN;
                    n = n + 3'd1;
                    l2s_cnt_next = pwrbtn_pkg::period(l2s_hold_reg);
                end
                if (e_l2s && l2s_cnt_next == '0)
                begin
                    batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_PRE_SHUTDOWN;
                    n = n + 3'd1;
                    shut_cnt_next = pwrbtn_pkg::period(shutdown_hold_reg);
                end
                if (e_shut && shut_cnt_next == '0)
                begin
                    halting_next = 1'b1;
                    batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_SHUTTING_DOWN;
                    n = n + 3'd1;
                    anim_cnt_next = pwrbtn_pkg::period(anim_hold_reg);
                end
                if (e_anim && anim_cnt_next == '0)
                begin
                    batch_ev_next[n[1:0]] = pwrbtn_pkg::EV_DIM_AND_SHUTDOWN;
                    n = n + 3'd1;
                end
            end
            default: ;
        endcase
        n_next = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_cnt_reg <= '0;
            l2s_cnt_reg  <= '0;
            shut_cnt_reg <= '0;
            anim_cnt_reg <= '0;
            halting_reg  <= 1'b0;
            in_vld_reg   <= 1'b0;
            rem_reg      <= 3'd0;
            idx_reg      <= 2'd0;
        end
        else
        begin
            if (item_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                lock_cnt_reg <= lock_cnt_next;
                l2s_cnt_reg  <= l2s_cnt_next;
                shut_cnt_reg <= shut_cnt_next;
                anim_cnt_reg <= anim_cnt_next;
                halting_reg  <= halting_next;
                rem_reg      <= n_next;
                idx_reg      <= 2'd0;
            end
            else if (take)
            begin
                rem_reg <= rem_reg - 3'd1;
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_reg <= item;
        end
        if (advance)
        begin
            batch_ev_reg <= batch_ev_next;
        end
    end

    assign res_valid     = (rem_reg != 3'd0);
    assign res.event_res = batch_ev_reg[idx_reg];
    assign res.last      = (rem_reg == 3'd1);

endmodule

### sv/pwrbtn_checker.sv
// Port-level checker for the power button hold sequencer, bound to the top level.
// Depends on pwrbtn_pkg for the transaction structs and event codes.
module pwrbtn_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_stall,
    input pwrbtn_pkg::result_t res
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
    else $error("A stalled result transaction changed or was dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.event_res <= pwrbtn_pkg::EV_DIM_AND_SHUTDOWN)
    else $error("A result transaction carries an undefined event code.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == pwrbtn_pkg::EV_DIM_AND_SHUTDOWN |-> res.last)
    else $error("Dim and shutdown was not the last event of its item.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.event_res == pwrbtn_pkg::EV_PRE_LOCK |-> res.last)
    else $error("Pre-lock was not the only event of its press.");

endmodule

bind power_button_hold_sequencer pwrbtn_checker u_pwrbtn_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
